>>> rtl/i2cms_pkg.sv
// i2cms_pkg: shared types and constants for the i2c master transfer sequencer
// no dependencies
package i2cms_pkg;

   // transmit buffer depth
   localparam int BUFFER_DEPTH = 256;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_READ   = 3'd2,
      OP_STATUS = 3'd3,
      OP_TMO    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   localparam logic [3:0] ST_START     = 4'd0;
   localparam logic [3:0] ST_RSTART    = 4'd1;
   localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
   localparam logic [3:0] ST_SLAW_NACK = 4'd3;
   localparam logic [3:0] ST_DW_ACK    = 4'd4;
   localparam logic [3:0] ST_DW_NACK   = 4'd5;
   localparam logic [3:0] ST_SLAR_ACK  = 4'd6;
   localparam logic [3:0] ST_SLAR_NACK = 4'd7;
   localparam logic [3:0] ST_DR_ACK    = 4'd8;
   localparam logic [3:0] ST_DR_NACK   = 4'd9;

   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_NAK     = 3'd1;
   localparam logic [2:0] RC_INVALID = 3'd2;
   localparam logic [2:0] RC_TIMEOUT = 3'd3;
   localparam logic [2:0] RC_BUSY    = 3'd4;
   localparam logic [2:0] RC_FULL    = 3'd5;

   localparam logic [1:0] CSR_SLAVE = 2'd0;
   localparam logic [1:0] CSR_ABYTES = 2'd1;
   localparam logic [1:0] CSR_LBYTES = 2'd2;
   localparam logic [1:0] CSR_REGADDR = 2'd3;

   // one queued command
   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] bus_status;
      logic [7:0] data_byte;
      logic [8:0] read_length;
   } cmd_type;

   // one result
   typedef struct packed {
      logic       dat_valid;
      logic [7:0] dat_value;
      logic       set_start;
      logic       clear_start;
      logic       set_stop;
      logic       set_ack;
      logic       clear_ack;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [7:0] rx_index;
      logic       done_res;
      logic [2:0] result_code;
   } rsp_type;

endpackage

>>> rtl/i2cms_ram.sv
// i2cms_ram: generic single port write, single port registered read memory
// no dependencies
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/i2cms_front.sv
// i2cms_front: accepts command beats into a short queue
// depends on i2cms_pkg
module i2cms_front import i2cms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    q_valid,
   input  logic    q_take,
   output cmd_type q_cmd
);
   cmd_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_take;
   assign q_cmd    = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // two entry queue
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) slot_ff[wp_ff] <= in_cmd;
   end
endmodule

>>> rtl/i2cms_back.sv
// i2cms_back: executes queued commands against transfer state
// depends on i2cms_pkg and i2cms_ram
module i2cms_back import i2cms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        q_valid,
   output logic        q_take,
   input  cmd_type     q_cmd,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_rsp
);
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   logic [6:0]  slave_ff;
   logic [2:0]  abytes_ff, lbytes_ff;
   logic [31:0] regaddr_ff;

   mode_type    mode_ff, mode_in;
   logic [2:0]  asent_ff, asent_in, lrecv_ff, lrecv_in;
   logic [31:0] lpre_ff, lpre_in;
   logic [8:0]  target_ff, target_in, bcnt_ff, bcnt_in;
   logic [FW-1:0] fill_ff, fill_in;

   // phase 0: ram read issued, phase 1: execute
   logic        phase_ff;
   logic        ovalid_ff;
   rsp_type     orsp_ff, r;
   logic        exec;
   logic [7:0]  rd_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   logic [2:0]  ab, lb;
   logic [7:0]  addr_w;
   logic [1:0]  sh;
   logic        nab_due;
   logic        wr_pend;
   logic        wr_more;

   assign ab = (abytes_ff > 3'd4) ? 3'd4 : abytes_ff;
   assign lb = (lbytes_ff > 3'd4) ? 3'd4 : lbytes_ff;
   assign addr_w = {slave_ff, 1'b0};
   assign nab_due = (asent_ff < ab);
   assign sh = 2'(ab - asent_ff - 3'd1);
   assign rd_addr = AW'(bcnt_ff);
   assign wr_addr = AW'(fill_ff);
   assign wr_pend = ({23'd0, bcnt_ff} < 32'(fill_ff));
   assign wr_more = wr_pend && (32'(bcnt_ff) < BUFFER_DEPTH);

   assign exec   = q_valid && phase_ff && (!ovalid_ff || out_ready);
   assign q_take = exec;
   assign wr_en  = exec && (q_cmd.operation == OP_PUSH) && (mode_ff == MODE_IDLE)
                   && (32'(fill_ff) < BUFFER_DEPTH);
   assign out_valid = ovalid_ff;
   assign out_rsp   = orsp_ff;

   i2cms_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(q_cmd.data_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // command execution
   always_comb begin
      r = '0;
      mode_in = mode_ff; asent_in = asent_ff; lrecv_in = lrecv_ff;
      lpre_in = lpre_ff; target_in = target_ff; bcnt_in = bcnt_ff; fill_in = fill_ff;
      unique case (q_cmd.operation)
         OP_PUSH: begin
            if (mode_ff != MODE_IDLE) r.result_code = RC_BUSY;
            else if (32'(fill_ff) >= BUFFER_DEPTH) r.result_code = RC_FULL;
            else fill_in = fill_ff + FW'(1);
         end
         OP_WRITE, OP_READ: begin
            if (mode_ff != MODE_IDLE) begin
               r.done_res = 1'b1; r.result_code = RC_BUSY;
            end else begin
               mode_in = (q_cmd.operation == OP_WRITE) ? MODE_WRITE : MODE_READ;
               asent_in = '0; lrecv_in = '0; lpre_in = '0; bcnt_in = '0;
               target_in = (q_cmd.operation == OP_READ) ? q_cmd.read_length : 9'd0;
               r.set_start = 1'b1; r.clear_ack = 1'b1;
            end
         end
         OP_STATUS: begin
            if (mode_ff == MODE_WRITE) begin
               priority if (q_cmd.bus_status == ST_START) begin
                  r.dat_valid = 1'b1; r.dat_value = addr_w; r.clear_start = 1'b1;
               end else if (q_cmd.bus_status == ST_SLAW_NACK ||
                            (q_cmd.bus_status == ST_DW_NACK && (wr_pend || nab_due))) begin
                  r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_NAK;
               end else if (q_cmd.bus_status == ST_SLAW_ACK || q_cmd.bus_status == ST_DW_ACK ||
                            q_cmd.bus_status == ST_DW_NACK) begin
                  if (nab_due) begin
                     asent_in = asent_ff + 3'd1;
                     r.dat_valid = 1'b1; r.dat_value = regaddr_ff[sh*8 +: 8];
                  end else if (wr_more) begin
                     r.dat_valid = 1'b1; r.dat_value = rd_data; bcnt_in = bcnt_ff + 9'd1;
                  end else begin
                     r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_OK;
                  end
               end else begin
                  r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_INVALID;
               end
               if (r.done_res) begin
                  fill_in = '0; mode_in = MODE_IDLE;
               end
            end else if (mode_ff == MODE_READ) begin
               priority if (q_cmd.bus_status == ST_START && ab != 3'd0) begin
                  r.dat_valid = 1'b1; r.dat_value = addr_w; r.clear_start = 1'b1;
               end else if (q_cmd.bus_status == ST_START || q_cmd.bus_status == ST_RSTART) begin
                  r.dat_valid = 1'b1; r.dat_value = addr_w | 8'd1; r.clear_start = 1'b1;
               end else if (q_cmd.bus_status == ST_SLAW_NACK || q_cmd.bus_status == ST_SLAR_NACK ||
                            (q_cmd.bus_status == ST_DW_NACK && nab_due)) begin
                  r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_NAK;
               end else if (q_cmd.bus_status == ST_SLAW_ACK || q_cmd.bus_status == ST_DW_ACK ||
                            q_cmd.bus_status == ST_DW_NACK) begin
                  if (nab_due) begin
                     asent_in = asent_ff + 3'd1;
                     r.dat_valid = 1'b1; r.dat_value = regaddr_ff[sh*8 +: 8];
                  end else begin
                     r.set_start = 1'b1;
                  end
               end else if (q_cmd.bus_status == ST_SLAR_ACK) begin
                  if (lb != 3'd0 || target_ff > 9'd1) r.set_ack = 1'b1;
                  else r.clear_ack = 1'b1;
               end else if (q_cmd.bus_status == ST_DR_ACK) begin
                  if (lrecv_ff < lb) begin
                     lpre_in = {lpre_ff[23:0], q_cmd.data_byte};
                     lrecv_in = lrecv_ff + 3'd1;
                     if (lrecv_in >= lb && {23'd0, target_ff} > lpre_in)
                        target_in = lpre_in[8:0];
                  end else begin
                     r.rx_valid = 1'b1; r.rx_byte = q_cmd.data_byte;
                     r.rx_index = bcnt_ff[7:0]; bcnt_in = bcnt_ff + 9'd1;
                  end
                  // ack decision uses the position after this byte
                  if (lrecv_in < lb || {1'b0, bcnt_in} + 10'd1 < {1'b0, target_in})
                     r.set_ack = 1'b1;
                  else r.clear_ack = 1'b1;
               end else if (q_cmd.bus_status == ST_DR_NACK) begin
                  r.rx_valid = 1'b1; r.rx_byte = q_cmd.data_byte;
                  r.rx_index = bcnt_ff[7:0]; bcnt_in = bcnt_ff + 9'd1;
                  r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_OK;
               end else begin
                  r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_INVALID;
               end
               if (r.done_res) mode_in = MODE_IDLE;
            end
         end
         OP_TMO: begin
            if (mode_ff != MODE_IDLE) begin
               r.set_stop = 1'b1; r.done_res = 1'b1; r.result_code = RC_TIMEOUT;
               if (mode_ff == MODE_WRITE) fill_in = '0;
               mode_in = MODE_IDLE;
            end
         end
         default: ;
      endcase
   end

   // state, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= '0; abytes_ff <= '0; lbytes_ff <= '0; regaddr_ff <= '0;
         mode_ff <= MODE_IDLE; asent_ff <= '0; lrecv_ff <= '0; lpre_ff <= '0;
         target_ff <= '0; bcnt_ff <= '0; fill_ff <= '0;
         phase_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLAVE:   slave_ff   <= csr_wdata[6:0];
               CSR_ABYTES:  abytes_ff  <= csr_wdata[2:0];
               CSR_LBYTES:  lbytes_ff  <= csr_wdata[2:0];
               CSR_REGADDR: regaddr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (exec) begin
            mode_ff <= mode_in; asent_ff <= asent_in; lrecv_ff <= lrecv_in;
            lpre_ff <= lpre_in; target_ff <= target_in; bcnt_ff <= bcnt_in;
            fill_ff <= fill_in;
            phase_ff <= 1'b0;
            ovalid_ff <= 1'b1;
         end else begin
            if (q_valid) phase_ff <= 1'b1;
            if (out_ready) ovalid_ff <= 1'b0;
         end
      end
      if (exec) orsp_ff <= r;
   end
endmodule

>>> rtl/i2c_master_transfer_sequencer_unit.sv
// i2c master transfer sequencer: front queue plus execution back end
// depends on i2cms_pkg, i2cms_front and i2cms_back
//
// Usage: commands and bus status events arrive on the req_ stream, one beat
// per command; each beat yields exactly one rsp_ beat with the actions to
// apply to the bus controller (load byte, start, stop, ack/nack), any
// received byte and the completion code. csr_ writes set slave address,
// register address byte count, length prefix byte count and register
// address; the user must make them only while idle, which the block
// itself does not enforce. Each command first issues the transmit buffer
// read, then executes and registers the result on rsp_; the buffer's
// registered read port sits ahead of each execution step, so the back end
// does not start a new command before the last result is registered.
// A two entry queue parts the req_ side from the execution step, so beats
// are still taken while a result waits on a stalled rsp_ side; when rsp_
// stalls, the result holds and the queue fills, then req_tready drops.
// Reset (synchronous, active high) clears configuration, transfer state
// and the transmit fill count; buffer contents stay undefined.
module i2c_master_transfer_sequencer_unit import i2cms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // operation, bus_status, data_byte, read_length
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,  // dat_valid, dat_value, set_start, clear_start,
                                   // set_stop, set_ack, clear_ack, rx_valid, rx_byte,
                                   // rx_index, done_res, result_code, zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   cmd_type in_cmd, q_cmd;
   rsp_type rsp;
   logic    q_valid, q_take;

   assign in_cmd.operation   = req_tdata[2:0];
   assign in_cmd.bus_status  = req_tdata[6:3];
   assign in_cmd.data_byte   = req_tdata[14:7];
   assign in_cmd.read_length = req_tdata[23:15];

   i2cms_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
   );

   i2cms_back u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {5'd0, rsp.result_code, rsp.done_res, rsp.rx_index, rsp.rx_byte,
                       rsp.rx_valid, rsp.clear_ack, rsp.set_ack, rsp.set_stop,
                       rsp.clear_start, rsp.set_start, rsp.dat_value, rsp.dat_valid};

   // a completion other than a busy refusal always carries stop
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.done_res && rsp.result_code != RC_BUSY |-> rsp.set_stop)
      else $error("done without stop");
   // never ack and nack together
   a_ack_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.set_ack && rsp.clear_ack))
      else $error("ack and nack together");
   // queue is never taken while empty
   a_q_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("queue taken empty");
endmodule

>>> tb/sv/tb_i2c_master_transfer_sequencer_unit.sv
// testbench for i2c_master_transfer_sequencer_unit: drives command and bus status beats,
// predicts every response beat and checks it field by field
// depends on i2cms_pkg and the unit under test
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer_unit;
   import i2cms_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // operation, bus_status, data_byte, read_length
   logic        rsp_tready = 1'b0;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;       // dat_valid, dat_value, set_start, clear_start, set_stop,
                                 // set_ack, clear_ack, rx_valid, rx_byte, rx_index,
                                 // done_res, result_code, zero pad
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   i2c_master_transfer_sequencer_unit u_dut (.*);

   always #1 clock = ~clock;

   // shadow configuration and transfer state
   logic [6:0]  cfg_slave;
   logic [2:0]  cfg_abytes, cfg_lbytes;
   logic [31:0] cfg_regaddr;
   mode_type    xfer_mode;
   int          addr_sent, len_rcvd, byte_cnt, tx_fill;
   logic [31:0] len_prefix, target_cnt;
   logic [7:0]  tx_buf [256];

   rsp_type     act;            // response worked out for the latest beat
   rsp_type     action_q [$];   // responses still owed by the unit
   int          errors = 0, beats_sent = 0, beats_checked = 0;
   bit          idle_en = 1'b1, hold_rsp = 1'b0;
   int          stall_left = 0;

   // ---------------------------------------------------------------- prediction
   function automatic int clamp4(logic [2:0] v);
      return (v > 4) ? 4 : int'(v);
   endfunction

   function automatic void load_byte(logic [7:0] v);
      act.dat_valid = 1'b1;
      act.dat_value = v;
   endfunction

   function automatic void end_transfer(logic [2:0] code);
      act.set_stop = 1'b1;
      act.done_res = 1'b1;
      act.result_code = code;
      if (xfer_mode == MODE_WRITE) tx_fill = 0;
      xfer_mode = MODE_IDLE;
   endfunction

   // next register address byte, most significant first
   function automatic bit next_reg_byte();
      int ab;
      ab = clamp4(cfg_abytes);
      if (addr_sent >= ab) return 1'b0;
      addr_sent++;
      load_byte(8'(cfg_regaddr >> ((ab - addr_sent) * 8)));
      return 1'b1;
   endfunction

   function automatic void deliver(logic [7:0] d);
      act.rx_valid = 1'b1;
      act.rx_byte = d;
      act.rx_index = 8'(byte_cnt);
      byte_cnt = (byte_cnt + 1) & 511;
   endfunction

   function automatic void write_advance();
      if (next_reg_byte()) return;
      if (byte_cnt < tx_fill) begin
         load_byte(tx_buf[byte_cnt]);
         byte_cnt++;
      end else begin
         end_transfer(RC_OK);
      end
   endfunction

   function automatic void write_status(logic [3:0] st);
      case (st)
         ST_START: begin
            load_byte({cfg_slave, 1'b0});
            act.clear_start = 1'b1;
         end
         ST_SLAW_NACK: end_transfer(RC_NAK);
         // nack only tolerated once everything has gone out
         ST_DW_NACK: begin
            if (byte_cnt < tx_fill || addr_sent < clamp4(cfg_abytes)) end_transfer(RC_NAK);
            else write_advance();
         end
         ST_SLAW_ACK, ST_DW_ACK: write_advance();
         default: end_transfer(RC_INVALID);
      endcase
   endfunction

   function automatic void read_status(logic [3:0] st, logic [7:0] d);
      int ab, lb;
      ab = clamp4(cfg_abytes);
      lb = clamp4(cfg_lbytes);
      case (st)
         ST_START: begin
            act.clear_start = 1'b1;
            load_byte({cfg_slave, (ab == 0) ? 1'b1 : 1'b0});
         end
         ST_RSTART: begin
            act.clear_start = 1'b1;
            load_byte({cfg_slave, 1'b1});
         end
         ST_SLAW_NACK, ST_SLAR_NACK: end_transfer(RC_NAK);
         ST_DW_NACK: begin
            if (addr_sent < ab) end_transfer(RC_NAK);
            else if (!next_reg_byte()) act.set_start = 1'b1;
         end
         ST_SLAW_ACK, ST_DW_ACK: begin
            if (!next_reg_byte()) act.set_start = 1'b1;
         end
         ST_SLAR_ACK: begin
            if (lb != 0 || target_cnt > 1) act.set_ack = 1'b1;
            else act.clear_ack = 1'b1;
         end
         // length prefix bytes first, then data
         ST_DR_ACK: begin
            if (len_rcvd < lb) begin
               len_prefix = {len_prefix[23:0], d};
               len_rcvd++;
               if (len_rcvd >= lb && target_cnt > len_prefix) target_cnt = len_prefix;
            end else begin
               deliver(d);
            end
            if (len_rcvd < lb || byte_cnt + 1 < target_cnt) act.set_ack = 1'b1;
            else act.clear_ack = 1'b1;
         end
         ST_DR_NACK: begin
            deliver(d);
            end_transfer(RC_OK);
         end
         default: end_transfer(RC_INVALID);
      endcase
   endfunction

   function automatic void predict_action(logic [2:0] op, logic [3:0] st, logic [7:0] d,
                                          logic [8:0] rl);
      act = '0;
      case (op)
         OP_PUSH: begin
            if (xfer_mode != MODE_IDLE) act.result_code = RC_BUSY;
            else if (tx_fill >= 256) act.result_code = RC_FULL;
            else begin
               tx_buf[tx_fill] = d;
               tx_fill++;
            end
         end
         OP_WRITE, OP_READ: begin
            if (xfer_mode != MODE_IDLE) begin
               act.done_res = 1'b1;
               act.result_code = RC_BUSY;
            end else begin
               xfer_mode = (op == OP_WRITE) ? MODE_WRITE : MODE_READ;
               addr_sent = 0;
               len_rcvd = 0;
               len_prefix = '0;
               byte_cnt = 0;
               target_cnt = (op == OP_READ) ? 32'(rl) : '0;
               act.set_start = 1'b1;
               act.clear_ack = 1'b1;
            end
         end
         OP_STATUS: begin
            if (xfer_mode == MODE_WRITE) write_status(st);
            else if (xfer_mode == MODE_READ) read_status(st, d);
         end
         OP_TMO: if (xfer_mode != MODE_IDLE) end_transfer(RC_TIMEOUT);
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report(string field, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("mismatch at %0t: beat %0d %s got %0h expected %0h",
               $realtime, beats_checked, field, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.dat_valid   = rsp_tdata[0];
         got.dat_value   = rsp_tdata[8:1];
         got.set_start   = rsp_tdata[9];
         got.clear_start = rsp_tdata[10];
         got.set_stop    = rsp_tdata[11];
         got.set_ack     = rsp_tdata[12];
         got.clear_ack   = rsp_tdata[13];
         got.rx_valid    = rsp_tdata[14];
         got.rx_byte     = rsp_tdata[22:15];
         got.rx_index    = rsp_tdata[30:23];
         got.done_res    = rsp_tdata[31];
         got.result_code = rsp_tdata[34:32];
         if (action_q.size() == 0) begin
            errors++;
            $display("unexpected response beat at %0t", $realtime);
         end else begin
            want = action_q.pop_front();
            if (got.dat_valid != want.dat_valid) report("dat_valid", got.dat_valid, want.dat_valid);
            if (got.dat_value != want.dat_value) report("dat_value", got.dat_value, want.dat_value);
            if (got.set_start != want.set_start) report("set_start", got.set_start, want.set_start);
            if (got.clear_start != want.clear_start)
               report("clear_start", got.clear_start, want.clear_start);
            if (got.set_stop != want.set_stop) report("set_stop", got.set_stop, want.set_stop);
            if (got.set_ack != want.set_ack) report("set_ack", got.set_ack, want.set_ack);
            if (got.clear_ack != want.clear_ack) report("clear_ack", got.clear_ack, want.clear_ack);
            if (got.rx_valid != want.rx_valid) report("rx_valid", got.rx_valid, want.rx_valid);
            if (got.rx_byte != want.rx_byte) report("rx_byte", got.rx_byte, want.rx_byte);
            if (got.rx_index != want.rx_index) report("rx_index", got.rx_index, want.rx_index);
            if (got.done_res != want.done_res) report("done_res", got.done_res, want.done_res);
            if (got.result_code != want.result_code)
               report("result_code", got.result_code, want.result_code);
         end
         beats_checked++;
      end
   end

   // response side ready, with random stall bursts and a long hold on request
   initial forever begin
      @(negedge clock);
      if (hold_rsp) rsp_tready <= 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      end
   end

   // ---------------------------------------------------------------- driving
   task automatic send_beat(logic [2:0] op, logic [3:0] st, logic [7:0] d, logic [8:0] rl);
      int gap;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {rl, d, st, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_action(op, st, d, rl);
      action_q.push_back(act);
      beats_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (action_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SLAVE:  cfg_slave = val[6:0];
         CSR_ABYTES: cfg_abytes = val[2:0];
         CSR_LBYTES: cfg_lbytes = val[2:0];
         default:    cfg_regaddr = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(logic [31:0] sa, logic [31:0] ab, logic [31:0] lb, logic [31:0] ra);
      wait_idle();
      csr_write(CSR_SLAVE, sa);
      csr_write(CSR_ABYTES, ab);
      csr_write(CSR_LBYTES, lb);
      csr_write(CSR_REGADDR, ra);
   endtask

   function automatic logic [7:0] rx_data();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
   endfunction

   // one transfer driven by the predicted bus actions, with some noise mixed in
   task automatic run_transfer(bit is_read, int n_push);
      rsp_type ctx;
      logic [3:0] st;
      int r, steps;
      repeat (n_push) send_beat(OP_PUSH, 4'($urandom), 8'($urandom), 9'($urandom));
      send_beat(is_read ? OP_READ : OP_WRITE, 4'($urandom), 8'($urandom),
                ($urandom_range(0, 9) == 0) ? 9'd256 : 9'($urandom_range(0, 12)));
      ctx = act;
      steps = 0;
      while (xfer_mode != MODE_IDLE) begin
         r = $urandom_range(0, 99);
         steps++;
         if (steps > 700 || r < 2) send_beat(OP_TMO, 4'($urandom), 8'($urandom), 9'($urandom));
         else if (r < 5) send_beat(OP_STATUS, 4'($urandom), rx_data(), 9'($urandom));
         else if (r < 8) send_beat(3'($urandom_range(0, 2)), 4'($urandom), 8'($urandom),
                                   9'($urandom));
         else begin
            r = $urandom_range(0, 99);
            if (ctx.set_start && ctx.clear_ack) st = ST_START;
            else if (!is_read) begin
               if (ctx.clear_start) st = (r < 5) ? ST_SLAW_NACK : ST_SLAW_ACK;
               else st = (r < 12) ? ST_DW_NACK : ST_DW_ACK;
            end else if (ctx.dat_valid && ctx.dat_value[0] && ctx.clear_start)
               st = (r < 5) ? ST_SLAR_NACK : ST_SLAR_ACK;
            else if (ctx.dat_valid) st = ctx.clear_start ? ST_SLAW_ACK :
                                         (r < 5) ? ST_DW_NACK : ST_DW_ACK;
            else if (ctx.set_start) st = ST_RSTART;
            else if (ctx.clear_ack) st = (r < 5) ? ST_DR_ACK : ST_DR_NACK;
            else st = ST_DR_ACK;
            send_beat(OP_STATUS, st, rx_data(), 9'($urandom));
            ctx = act;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      set_config(32'h7f, 32'd7, 32'd0, 32'ha5c3_0f81);
      send_beat(OP_STATUS, ST_START, 8'h00, 9'd0);     // status while idle
      send_beat(OP_TMO, 4'd0, 8'h00, 9'd0);            // timeout while idle
      send_beat(3'd5, 4'd0, 8'h00, 9'd0);              // unused codes
      send_beat(3'd7, 4'hf, 8'hff, 9'h1ff);
      send_beat(OP_PUSH, 4'd0, 8'hff, 9'd0);
      send_beat(OP_PUSH, 4'd0, 8'h00, 9'd0);
      send_beat(OP_WRITE, 4'd0, 8'h00, 9'd0);
      send_beat(OP_PUSH, 4'd0, 8'h5a, 9'd0);           // push while busy
      send_beat(OP_READ, 4'd0, 8'h00, 9'd256);         // read while busy
      send_beat(OP_STATUS, ST_START, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_SLAW_ACK, 8'h00, 9'd0);
      repeat (4) send_beat(OP_STATUS, ST_DW_ACK, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_DW_ACK, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_DW_ACK, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_DW_NACK, 8'h00, 9'd0);   // nack after the transfer ended is ignored
      send_beat(OP_READ, 4'd0, 8'h00, 9'd0);
      send_beat(OP_STATUS, 4'hf, 8'h00, 9'd0);         // bad status forces stop
      set_config(32'h0, 32'd0, 32'd4, 32'h0);
      send_beat(OP_READ, 4'd0, 8'h00, 9'd1);
      send_beat(OP_STATUS, ST_START, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_SLAR_ACK, 8'h00, 9'd0);
      repeat (4) send_beat(OP_STATUS, ST_DR_ACK, 8'h00, 9'd0);  // prefix of zero
      send_beat(OP_STATUS, ST_DR_NACK, 8'hc3, 9'd0);
   endtask

   // fill the buffer to the top, one push too many, then send it all
   task automatic test_buffer_full();
      set_config(32'h2a, 32'd2, 32'd0, 32'h0000_1234);
      repeat (257) send_beat(OP_PUSH, 4'd0, 8'($urandom), 9'd0);
      run_transfer(1'b0, 0);
   endtask

   // data acks past the requested count, so the byte position wraps
   task automatic test_long_read();
      set_config(32'h55, 32'd0, 32'd0, 32'hffff_ffff);
      send_beat(OP_READ, 4'd0, 8'h00, 9'd256);
      send_beat(OP_STATUS, ST_START, 8'h00, 9'd0);
      send_beat(OP_STATUS, ST_SLAR_ACK, 8'h00, 9'd0);
      repeat (520) send_beat(OP_STATUS, ST_DR_ACK, 8'($urandom), 9'd0);
      send_beat(OP_STATUS, ST_DR_NACK, 8'($urandom), 9'd0);
   endtask

   // response side held off while requests keep coming, then a full drain
   task automatic test_backpressure();
      wait_idle();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (80) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      run_transfer(1'b0, 6);
      wait_idle();
   endtask

   task automatic test_random();
      int r;
      while (beats_sent < 1650) begin
         r = $urandom_range(0, 3);
         if (r == 0) set_config(32'h0, 32'd0, 32'd0, 32'h0);
         else if (r == 1) set_config(32'hffff_ffff, 32'd4, 32'd4, 32'hffff_ffff);
         else set_config($urandom, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
         repeat ($urandom_range(3, 8)) begin
            run_transfer($urandom_range(0, 1),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 6));
            if (beats_sent > 1450) idle_en = 1'b0;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_buffer_full();
      test_long_read();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d request beats and %0d response beats: writes, reads, length prefixes,",
               beats_sent, beats_checked);
      $display("busy and full refusals, bad status, timeouts and long response stalls");
      if (errors == 0 && action_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
